@@ sv/fatre_pkg.sv @@
package fatre_pkg;

    // Defaults for the top-level parameters
    localparam int FAT_ENTRIES_DEF  = 65536;
    localparam int MAX_SEGMENTS_DEF = 64;

    // Stream word widths (bits, zero padded)
    localparam int IN_W  = 192;
    localparam int OUT_W = 96;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] CHAIN_END   = 16'hFFF8;
    localparam logic [7:0]  ATTR_DIR    = 8'h10;
    localparam logic [7:0]  ATTR_VOLUME = 8'h08;
    localparam logic [19:0] SEG_MAX     = 20'hFFFFF;

    typedef enum logic [1:0] {
        OP_FAT_WRITE = 2'd0,
        OP_OPEN      = 2'd1,
        OP_SEEK      = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ORG_START   = 2'd0,
        ORG_CURRENT = 2'd1,
        ORG_END     = 2'd2,
        ORG_BAD     = 2'd3
    } origin_t;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_OPEN_REJECT = 3'd1,
        STS_SEEK_RANGE  = 3'd2,
        STS_CHAIN_END   = 3'd3,
        STS_EOF         = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        REG_BYTES_PER_SECTOR    = 3'd0,
        REG_SECTORS_PER_CLUSTER = 3'd1,
        REG_RESERVED_SECTORS    = 3'd2,
        REG_FAT_COUNT           = 3'd3,
        REG_FAT_SIZE            = 3'd4,
        REG_ROOT_ENTRY_COUNT    = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        ENG_IDLE,
        ENG_PREP,
        ENG_SEEK_DT,
        ENG_SEEK_DP,
        ENG_WALK,
        ENG_WALK_WAIT,
        ENG_RD_ROOT,
        ENG_RD_WITHIN,
        ENG_SEG,
        ENG_ADDR1,
        ENG_ADDR2,
        ENG_EMIT,
        ENG_NEXT_WAIT
    } eng_state_t;

    // Volume geometry
    typedef struct packed {
        logic [12:0] bytes_per_sector;
        logic [7:0]  sectors_per_cluster;
        logic [15:0] reserved_sectors;
        logic [2:0]  fat_count;
        logic [15:0] fat_size;
        logic [15:0] root_entry_count;
    } cfg_t;

    // Classified command as queued for the back end
    typedef struct packed {
        op_t                op;
        logic [15:0]        fat_index;
        logic [15:0]        fat_value;
        logic [15:0]        first_cluster;
        logic [31:0]        file_length;
        logic               open_ok;
        logic signed [32:0] seek_offset;
        origin_t            seek_origin;
        logic [31:0]        read_req;
    } cmd_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [20:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [20:0] rem;
    } div_rsp_t;

    function automatic logic usable(input logic [15:0] c);
        return (c >= 16'd2) && (c < CHAIN_END);
    endfunction

endpackage

@@ sv/fat16_file_read_address_engine.sv @@
// FAT16 file read address engine: FAT load, open, seek and read commands.
// FAT write and open: done in PREP; the next pop waits until the result word is taken.
// Seek: divide target and position by cluster size; walk the FAT if they differ.
// Read: two divides, then states SEG, ADDR1, ADDR2, EMIT per word, NEXT_WAIT per hop.
// Commands queue two deep in front, so input words are taken while the back end works.
// Reset: geometry to defaults, file state zero; FAT contents undefined until written.
module fat16_file_read_address_engine
    import fatre_pkg::*;
#(
    parameter int FAT_ENTRIES  = FAT_ENTRIES_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // fat_index[15:0], fat_value[31:16], first_cluster[47:32], file_length[79:48],
    // attributes[87:80], seek_offset[120:88], seek_origin[122:121],
    // read_length[154:123], buffer_size[186:155]
    input  logic [IN_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status[2:0], disk_offset[38:3], byte_count[58:39], position[90:59]
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    reg_index_t reg_idx;
    logic       q_valid;
    logic       q_pop;
    cmd_t       q_item;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = reg_index_t'(paddr[4:2]);

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_BYTES_PER_SECTOR:    cfg_next.bytes_per_sector    = pwdata[12:0];
                REG_SECTORS_PER_CLUSTER: cfg_next.sectors_per_cluster = pwdata[7:0];
                REG_RESERVED_SECTORS:    cfg_next.reserved_sectors    = pwdata[15:0];
                REG_FAT_COUNT:           cfg_next.fat_count           = pwdata[2:0];
                REG_FAT_SIZE:            cfg_next.fat_size            = pwdata[15:0];
                REG_ROOT_ENTRY_COUNT:    cfg_next.root_entry_count    = pwdata[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_BYTES_PER_SECTOR:    prdata = {19'd0, cfg_reg.bytes_per_sector};
            REG_SECTORS_PER_CLUSTER: prdata = {24'd0, cfg_reg.sectors_per_cluster};
            REG_RESERVED_SECTORS:    prdata = {16'd0, cfg_reg.reserved_sectors};
            REG_FAT_COUNT:           prdata = {29'd0, cfg_reg.fat_count};
            REG_FAT_SIZE:            prdata = {16'd0, cfg_reg.fat_size};
            REG_ROOT_ENTRY_COUNT:    prdata = {16'd0, cfg_reg.root_entry_count};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_sector    <= 13'd512;
            cfg_reg.sectors_per_cluster <= 8'd4;
            cfg_reg.reserved_sectors    <= 16'd1;
            cfg_reg.fat_count           <= 3'd2;
            cfg_reg.fat_size            <= 16'd256;
            cfg_reg.root_entry_count    <= 16'd512;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fatre_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    fatre_back #(
        .FAT_ENTRIES  (FAT_ENTRIES),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ sv/fatre_front.sv @@
module fatre_front
    import fatre_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    // fat_index, fat_value, first_cluster, file_length, attributes,
    // seek_offset, seek_origin, read_length, buffer_size
    input  logic [IN_W-1:0] s_tdata,
    // opcode
    input  logic [1:0]      s_tuser,
    output logic            q_valid,
    output cmd_t            q_item,
    input  logic            q_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          q_mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    cmd_t        cls;
    logic [7:0]  attr;
    logic [31:0] rd_len;
    logic [31:0] buf_size;
    logic        push;

    // Classify the incoming word
    always_comb
    begin
        attr             = s_tdata[87:80];
        rd_len           = s_tdata[154:123];
        buf_size         = s_tdata[186:155];
        cls.op           = op_t'(s_tuser);
        cls.fat_index    = s_tdata[15:0];
        cls.fat_value    = s_tdata[31:16];
        cls.first_cluster= s_tdata[47:32];
        cls.file_length  = s_tdata[79:48];
        cls.open_ok      = ((attr & (ATTR_DIR | ATTR_VOLUME)) == 8'd0);
        cls.seek_offset  = s_tdata[120:88];
        cls.seek_origin  = origin_t'(s_tdata[122:121]);
        cls.read_req     = (rd_len < buf_size) ? rd_len : buf_size;
    end

    assign s_tready = (count_reg != CW'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ sv/fatre_div.sv @@
module fatre_div
    import fatre_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    // One quotient bit per cycle, restoring
    localparam int STEPS = 32;
    localparam int CNTW  = $clog2(STEPS);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [20:0]     rem_reg, rem_next;
    logic [31:0]     quot_reg, quot_next;
    logic [20:0]     dvs_reg, dvs_next;
    logic [22:0]     trial;

    always_comb
    begin
        trial     = {1'b0, rem_reg, quot_reg[31]} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quot_next = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial[22])
            begin
                rem_next = {rem_reg[19:0], quot_reg[31]};
            end
            else
            begin
                rem_next = trial[20:0];
            end
            quot_next = {quot_reg[30:0], ~trial[22]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ sv/fatre_back.sv @@
module fatre_back
    import fatre_pkg::*;
#(
    parameter int FAT_ENTRIES  = FAT_ENTRIES_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             q_valid,
    input  cmd_t             q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status, disk_offset, byte_count, position
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    localparam int AW = $clog2(FAT_ENTRIES);
    localparam int KW = $clog2(MAX_SEGMENTS + 1);

    eng_state_t state_reg, state_next;

    cmd_t        cmd_reg, cmd_next;
    logic [15:0] start_cl_reg, start_cl_next;
    logic [15:0] cur_cl_reg, cur_cl_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] pos_reg, pos_next;
    logic [20:0] cs_reg, cs_next;
    logic [31:0] target_reg, target_next;
    logic [31:0] qt_reg, qt_next;
    logic [31:0] steps_reg, steps_next;
    logic        steps_nz_reg, steps_nz_next;
    logic [15:0] walk_reg, walk_next;
    logic [18:0] fcfs_reg, fcfs_next;
    logic [21:0] base_reg, base_next;
    logic [20:0] within_reg, within_next;
    logic [31:0] rem_reg, rem_next;
    logic [KW-1:0] k_reg, k_next;
    logic [19:0] seg_reg, seg_next;
    logic [23:0] seca_reg, seca_next;
    logic [24:0] sec_reg, sec_next;
    logic        fetch_reg, fetch_next;
    logic        oob_reg, oob_next;

    logic        out_valid_reg, out_valid_next;
    status_t     out_status_reg, out_status_next;
    logic [35:0] out_offset_reg, out_offset_next;
    logic [19:0] out_count_reg, out_count_next;
    logic [31:0] out_pos_reg, out_pos_next;
    logic        out_last_reg, out_last_next;

    // FAT storage
    logic [15:0]   fat_mem [FAT_ENTRIES];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [15:0]   mem_q;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Shared datapath terms
    logic [12:0] bps_eff;
    logic [7:0]  spc_eff;
    logic [20:0] cs_now;
    logic [33:0] base_ext;
    logic [33:0] target;
    logic        seek_bad;
    logic [31:0] avail;
    logic [31:0] n_clip;
    logic [31:0] root_num;
    logic [20:0] cs_left;
    logic [31:0] seg_w;
    logic [19:0] seg_now;
    logic [23:0] seca_now;
    logic [37:0] prod;
    logic [20:0] within_after;
    logic [31:0] rem_after;
    logic [KW-1:0] k_after;
    logic [15:0] rd_cl;
    logic [15:0] fat_rd;
    logic        idx_ok;
    logic        walk_oob;
    logic        cur_oob;

    fatre_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        bps_eff  = (cfg.bytes_per_sector == '0) ? 13'd1 : cfg.bytes_per_sector;
        spc_eff  = (cfg.sectors_per_cluster == '0) ? 8'd1 : cfg.sectors_per_cluster;
        cs_now   = {8'd0, bps_eff} * {13'd0, spc_eff};
        case (cmd_reg.seek_origin)
            ORG_CURRENT: base_ext = {2'b00, pos_reg};
            ORG_END:     base_ext = {2'b00, size_reg};
            default:     base_ext = '0;
        endcase
        target   = base_ext + {cmd_reg.seek_offset[32], cmd_reg.seek_offset};
        seek_bad = (cmd_reg.seek_origin == ORG_BAD) || target[33]
                   || (target[32:0] > {1'b0, size_reg});
        avail    = size_reg - pos_reg;
        n_clip   = (avail < cmd_reg.read_req) ? avail : cmd_reg.read_req;
        root_num = {11'd0, cfg.root_entry_count, 5'd0} + {19'd0, bps_eff} - 32'd1;
        cs_left  = cs_reg - within_reg;
        seg_w    = ({11'd0, cs_left} < rem_reg) ? {11'd0, cs_left} : rem_reg;
        seg_now  = (seg_w > {12'd0, SEG_MAX}) ? SEG_MAX : seg_w[19:0];
        seca_now = {8'd0, cur_cl_reg - 16'd2} * {16'd0, spc_eff};
        prod     = {13'd0, sec_reg} * {25'd0, bps_eff};
        within_after = within_reg + {1'b0, seg_reg};
        rem_after    = rem_reg - {12'd0, seg_reg};
        k_after      = k_reg + 1'b1;
        idx_ok   = ({1'b0, cmd_reg.fat_index} < 17'(FAT_ENTRIES));
        walk_oob = ({1'b0, walk_reg} >= 17'(FAT_ENTRIES));
        cur_oob  = ({1'b0, cur_cl_reg} >= 17'(FAT_ENTRIES));
        rd_cl    = (state_reg == ENG_WALK) ? walk_reg : cur_cl_reg;
        mem_ra   = rd_cl[AW-1:0];
        mem_wa   = cmd_reg.fat_index[AW-1:0];
        fat_rd   = oob_reg ? 16'hFFFF : mem_q;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ENG_PREP;
                end
            end
            ENG_PREP:
            begin
                case (cmd_reg.op)
                    OP_SEEK:
                    begin
                        state_next = seek_bad ? ENG_EMIT : ENG_SEEK_DT;
                    end
                    OP_READ:
                    begin
                        if (pos_reg >= size_reg || n_clip == '0)
                        begin
                            state_next = ENG_EMIT;
                        end
                        else
                        begin
                            state_next = ENG_RD_ROOT;
                        end
                    end
                    default: state_next = ENG_EMIT;
                endcase
            end
            ENG_SEEK_DT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ENG_SEEK_DP;
                end
            end
            ENG_SEEK_DP:
            begin
                if (div_rsp.done)
                begin
                    state_next = (div_rsp.quot == qt_reg) ? ENG_EMIT : ENG_WALK;
                end
            end
            ENG_WALK:
            begin
                if (steps_reg == '0 || !usable(walk_reg))
                begin
                    state_next = ENG_EMIT;
                end
                else
                begin
                    state_next = ENG_WALK_WAIT;
                end
            end
            ENG_WALK_WAIT: state_next = ENG_WALK;
            ENG_RD_ROOT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ENG_RD_WITHIN;
                end
            end
            ENG_RD_WITHIN:
            begin
                if (div_rsp.done)
                begin
                    state_next = ENG_SEG;
                end
            end
            ENG_SEG:   state_next = usable(cur_cl_reg) ? ENG_ADDR1 : ENG_EMIT;
            ENG_ADDR1: state_next = ENG_ADDR2;
            ENG_ADDR2: state_next = ENG_EMIT;
            ENG_EMIT:
            begin
                if (m_tready)
                begin
                    if (fetch_reg)
                    begin
                        state_next = ENG_NEXT_WAIT;
                    end
                    else if (out_last_reg)
                    begin
                        state_next = ENG_IDLE;
                    end
                    else
                    begin
                        state_next = ENG_SEG;
                    end
                end
            end
            ENG_NEXT_WAIT: state_next = out_last_reg ? ENG_IDLE : ENG_SEG;
            default:       state_next = ENG_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cmd_next        = cmd_reg;
        start_cl_next   = start_cl_reg;
        cur_cl_next     = cur_cl_reg;
        size_next       = size_reg;
        pos_next        = pos_reg;
        cs_next         = cs_reg;
        target_next     = target_reg;
        qt_next         = qt_reg;
        steps_next      = steps_reg;
        steps_nz_next   = steps_nz_reg;
        walk_next       = walk_reg;
        fcfs_next       = fcfs_reg;
        base_next       = base_reg;
        within_next     = within_reg;
        rem_next        = rem_reg;
        k_next          = k_reg;
        seg_next        = seg_reg;
        seca_next       = seca_reg;
        sec_next        = sec_reg;
        fetch_next      = fetch_reg;
        oob_next        = oob_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;
        out_count_next  = out_count_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        div_req.start   = 1'b0;
        div_req.dividend= {11'd0, cs_now};
        div_req.divisor = cs_reg;

        case (state_reg)
            ENG_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_item;
                end
            end
            ENG_PREP:
            begin
                // single-word results default
                out_offset_next = '0;
                out_count_next  = '0;
                out_last_next   = 1'b1;
                out_status_next = STS_OK;
                out_pos_next    = pos_reg;
                fetch_next      = 1'b0;
                cs_next         = cs_now;
                fcfs_next       = {16'd0, cfg.fat_count} * {3'd0, cfg.fat_size};
                case (cmd_reg.op)
                    OP_FAT_WRITE:
                    begin
                        mem_we         = idx_ok;
                        out_valid_next = 1'b1;
                    end
                    OP_OPEN:
                    begin
                        out_valid_next = 1'b1;
                        if (cmd_reg.open_ok)
                        begin
                            start_cl_next = cmd_reg.first_cluster;
                            cur_cl_next   = cmd_reg.first_cluster;
                            size_next     = cmd_reg.file_length;
                            pos_next      = '0;
                            out_pos_next  = '0;
                        end
                        else
                        begin
                            out_status_next = STS_OPEN_REJECT;
                        end
                    end
                    OP_SEEK:
                    begin
                        target_next = target[31:0];
                        if (seek_bad)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STS_SEEK_RANGE;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = target[31:0];
                            div_req.divisor  = cs_now;
                        end
                    end
                    OP_READ:
                    begin
                        rem_next = n_clip;
                        k_next   = '0;
                        if (pos_reg >= size_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STS_EOF;
                        end
                        else if (n_clip == '0)
                        begin
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = root_num;
                            div_req.divisor  = {8'd0, bps_eff};
                        end
                    end
                    default: out_valid_next = 1'b1;
                endcase
            end
            ENG_SEEK_DT:
            begin
                if (div_rsp.done)
                begin
                    qt_next          = div_rsp.quot;
                    div_req.start    = 1'b1;
                    div_req.dividend = pos_reg;
                end
            end
            ENG_SEEK_DP:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quot == qt_reg)
                    begin
                        pos_next       = target_reg;
                        out_pos_next   = target_reg;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        steps_next    = qt_reg;
                        steps_nz_next = (qt_reg != '0);
                        walk_next     = start_cl_reg;
                    end
                end
            end
            ENG_WALK:
            begin
                oob_next = walk_oob;
                if (steps_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    if (steps_nz_reg && !usable(walk_reg) && target_reg < size_reg)
                    begin
                        out_status_next = STS_CHAIN_END;
                    end
                    else
                    begin
                        cur_cl_next  = walk_reg;
                        pos_next     = target_reg;
                        out_pos_next = target_reg;
                    end
                end
                else if (!usable(walk_reg))
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STS_CHAIN_END;
                end
            end
            ENG_WALK_WAIT:
            begin
                walk_next  = fat_rd;
                steps_next = steps_reg - 32'd1;
            end
            ENG_RD_ROOT:
            begin
                if (div_rsp.done)
                begin
                    base_next        = {6'd0, cfg.reserved_sectors} + {3'd0, fcfs_reg}
                                       + div_rsp.quot[21:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = pos_reg;
                end
            end
            ENG_RD_WITHIN:
            begin
                if (div_rsp.done)
                begin
                    within_next = div_rsp.rem;
                end
            end
            ENG_SEG:
            begin
                seg_next  = seg_now;
                seca_next = seca_now;
                if (!usable(cur_cl_reg))
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STS_CHAIN_END;
                    out_offset_next = '0;
                    out_count_next  = '0;
                    out_pos_next    = pos_reg;
                    out_last_next   = 1'b1;
                    fetch_next      = 1'b0;
                end
            end
            ENG_ADDR1:
            begin
                sec_next = {1'b0, seca_reg} + {3'd0, base_reg};
            end
            ENG_ADDR2:
            begin
                out_valid_next  = 1'b1;
                out_status_next = STS_OK;
                out_offset_next = prod[35:0] + {15'd0, within_reg};
                out_count_next  = seg_reg;
                pos_next        = pos_reg + {12'd0, seg_reg};
                out_pos_next    = pos_reg + {12'd0, seg_reg};
                rem_next        = rem_after;
                within_next     = within_after;
                k_next          = k_after;
                out_last_next   = (rem_after == '0) || (k_after == KW'(MAX_SEGMENTS));
                fetch_next      = (within_after == cs_reg);
            end
            ENG_EMIT:
            begin
                oob_next = cur_oob;
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                end
            end
            ENG_NEXT_WAIT:
            begin
                cur_cl_next = fat_rd;
                within_next = '0;
                fetch_next  = 1'b0;
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            start_cl_reg  <= '0;
            cur_cl_reg    <= '0;
            size_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            fetch_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_cl_reg  <= start_cl_next;
            cur_cl_reg    <= cur_cl_next;
            size_reg      <= size_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            fetch_reg     <= fetch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        cs_reg         <= cs_next;
        target_reg     <= target_next;
        qt_reg         <= qt_next;
        steps_reg      <= steps_next;
        steps_nz_reg   <= steps_nz_next;
        walk_reg       <= walk_next;
        fcfs_reg       <= fcfs_next;
        base_reg       <= base_next;
        within_reg     <= within_next;
        rem_reg        <= rem_next;
        k_reg          <= k_next;
        seg_reg        <= seg_next;
        seca_reg       <= seca_next;
        sec_reg        <= sec_next;
        oob_reg        <= oob_next;
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
        out_count_reg  <= out_count_next;
        out_pos_reg    <= out_pos_next;
        out_last_reg   <= out_last_next;
    end

    // FAT memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fat_mem[mem_wa] <= cmd_reg.fat_value;
        end
        mem_q <= fat_mem[mem_ra];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_pos_reg, out_count_reg, out_offset_reg, out_status_reg};

endmodule

@@ dv/fat16_file_read_address_engine_tb.sv @@
module fat16_file_read_address_engine_tb;
    import fatre_pkg::*;

    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          POOL_TOP    = 15;     // clusters 2..15 are always loaded
    localparam int          SEG_LIMIT   = MAX_SEGMENTS_DEF;
    localparam logic [35:0] ADDR_MASK   = 36'hF_FFFF_FFFF;

    // One command word as the sender sees it
    typedef struct {
        op_t         op;
        logic [15:0] fat_index;
        logic [15:0] fat_value;
        logic [15:0] first_cluster;
        logic [31:0] file_length;
        logic [7:0]  attributes;
        logic [32:0] seek_offset;
        origin_t     seek_origin;
        logic [31:0] read_length;
        logic [31:0] buffer_size;
    } fat_cmd_t;

    // One result word
    typedef struct {
        status_t     status;
        logic [35:0] disk_offset;
        logic [19:0] byte_count;
        logic [31:0] position;
        logic        last;
    } seg_word_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [4:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    fat16_file_read_address_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the engine: geometry, FAT and open file
    logic [12:0] g_bps;
    logic [7:0]  g_spc;
    logic [15:0] g_reserved;
    logic [2:0]  g_fat_count;
    logic [15:0] g_fat_size;
    logic [15:0] g_root_entries;
    logic [15:0] fat_mem [0:65535];
    logic [15:0] f_start;
    logic [15:0] f_cluster;
    logic [31:0] f_size;
    logic [31:0] f_pos;

    seg_word_t   expected_words[$];
    int          mismatches;
    int          words_checked;
    int          cmds_sent;
    int          cycle_count;
    int          hold_left;
    bit          calm;

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_words.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        $display("mismatch %s: got 0x%0h expected 0x%0h (word %0d)", what, got, want,
                 words_checked);
    endtask

    function automatic bit cluster_ok(logic [15:0] c);
        return c >= 16'd2 && c < 16'hFFF8;
    endfunction

    function automatic longint unsigned eff_bps();
        return (g_bps == 0) ? 1 : g_bps;
    endfunction

    function automatic longint unsigned cluster_size();
        return eff_bps() * ((g_spc == 0) ? 1 : g_spc);
    endfunction

    function automatic logic [35:0] disk_address(logic [15:0] c, longint unsigned in_off);
        longint unsigned bps;
        longint unsigned root;
        longint unsigned base;
        longint unsigned sec;
        bps  = eff_bps();
        root = (longint'(g_root_entries) * 32 + bps - 1) / bps;
        base = longint'(g_reserved) + longint'(g_fat_count) * g_fat_size + root;
        sec  = longint'(c - 16'd2) * ((g_spc == 0) ? 1 : g_spc) + base;
        return 36'((sec * bps + in_off) & ADDR_MASK);
    endfunction

    function automatic seg_word_t make_word(status_t st, logic [35:0] off, logic [19:0] cnt,
                                            logic last);
        seg_word_t w;
        w.status      = st;
        w.disk_offset = off;
        w.byte_count  = cnt;
        w.position    = f_pos;
        w.last        = last;
        return w;
    endfunction

    // Seek: returns status, updates shadow only on success
    function automatic status_t seek_file(logic [32:0] raw, origin_t org);
        longint          off;
        longint          base;
        longint          target;
        longint unsigned cs;
        longint unsigned steps;
        logic [15:0]     c;
        cs  = cluster_size();
        off = longint'($signed(raw));
        case (org)
            ORG_START:   base = 0;
            ORG_CURRENT: base = f_pos;
            ORG_END:     base = f_size;
            default:     return STS_SEEK_RANGE;
        endcase
        target = base + off;
        if (target < 0 || target > longint'(f_size))
            return STS_SEEK_RANGE;
        if (longint'(target) / cs == longint'(f_pos) / cs)
        begin
            f_pos = target[31:0];
            return STS_OK;
        end
        steps = target / cs;
        c = f_start;
        for (longint unsigned i = 0; i < steps; i++)
        begin
            if (!cluster_ok(c))
                return STS_CHAIN_END;
            c = fat_mem[c];
        end
        if (steps > 0 && !cluster_ok(c) && target < longint'(f_size))
            return STS_CHAIN_END;
        f_cluster = c;
        f_pos     = target[31:0];
        return STS_OK;
    endfunction

    // Read: fills the segment list for one request
    task automatic read_segments(fat_cmd_t cmd, ref seg_word_t segs[$]);
        longint unsigned cs;
        longint unsigned n;
        longint unsigned done;
        longint unsigned in_off;
        longint unsigned seg;
        logic [35:0]     addr;
        cs   = cluster_size();
        done = 0;
        if (f_pos >= f_size)
        begin
            segs.push_back(make_word(STS_EOF, 0, 0, 1'b1));
            return;
        end
        n = f_size - f_pos;
        if (cmd.read_length < n) n = cmd.read_length;
        if (cmd.buffer_size < n) n = cmd.buffer_size;
        if (n == 0)
        begin
            segs.push_back(make_word(STS_OK, 0, 0, 1'b1));
            return;
        end
        while (done < n && segs.size() < SEG_LIMIT)
        begin
            if (!cluster_ok(f_cluster))
            begin
                segs.push_back(make_word(STS_CHAIN_END, 0, 0, 1'b0));
                break;
            end
            in_off = f_pos % cs;
            seg    = cs - in_off;
            if (seg > n - done) seg = n - done;
            if (seg > SEG_MAX) seg = SEG_MAX;
            addr   = disk_address(f_cluster, in_off);
            f_pos  = f_pos + seg[31:0];
            done  += seg;
            segs.push_back(make_word(STS_OK, addr, seg[19:0], 1'b0));
            if (f_pos % cs == 0)
                f_cluster = fat_mem[f_cluster];
        end
        segs[segs.size() - 1].last = 1'b1;
    endtask

    // Work out the result words of one accepted command
    task automatic predict_words(fat_cmd_t cmd);
        seg_word_t segs[$];
        status_t   st;
        st = STS_OK;
        case (cmd.op)
            OP_FAT_WRITE: fat_mem[cmd.fat_index] = cmd.fat_value;
            OP_OPEN:
            begin
                if ((cmd.attributes & (ATTR_DIR | ATTR_VOLUME)) != 0)
                    st = STS_OPEN_REJECT;
                else
                begin
                    f_start   = cmd.first_cluster;
                    f_cluster = cmd.first_cluster;
                    f_size    = cmd.file_length;
                    f_pos     = 0;
                end
            end
            OP_SEEK:      st = seek_file(cmd.seek_offset, cmd.seek_origin);
            default:      read_segments(cmd, segs);
        endcase
        if (cmd.op != OP_READ)
            segs.push_back(make_word(st, 0, 0, 1'b1));
        foreach (segs[i])
            expected_words.push_back(segs[i]);
    endtask

    // Send one command word, with random idle cycles ahead of it unless calm
    task automatic send_cmd(fat_cmd_t cmd);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd.op;
        s_tdata  <= {5'd0, cmd.buffer_size, cmd.read_length, cmd.seek_origin, cmd.seek_offset,
                     cmd.attributes, cmd.file_length, cmd.first_cluster, cmd.fat_value,
                     cmd.fat_index};
        do
            @(posedge clk);
        while (!s_tready);
        predict_words(cmd);
        cmds_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    function automatic fat_cmd_t blank_cmd(op_t op);
        fat_cmd_t c;
        c.op            = op;
        c.fat_index     = 16'($urandom());
        c.fat_value     = 16'($urandom());
        c.first_cluster = 16'($urandom());
        c.file_length   = $urandom();
        c.attributes    = 8'($urandom());
        c.seek_offset   = {1'($urandom_range(0, 1)), $urandom()};
        c.seek_origin   = origin_t'($urandom_range(0, 3));
        c.read_length   = $urandom();
        c.buffer_size   = $urandom();
        return c;
    endfunction

    task automatic fat_write(logic [15:0] idx, logic [15:0] val);
        fat_cmd_t c;
        c = blank_cmd(OP_FAT_WRITE);
        c.fat_index = idx;
        c.fat_value = val;
        send_cmd(c);
    endtask

    task automatic open_file(logic [15:0] first, logic [31:0] len, logic [7:0] attr);
        fat_cmd_t c;
        c = blank_cmd(OP_OPEN);
        c.first_cluster = first;
        c.file_length   = len;
        c.attributes    = attr;
        send_cmd(c);
    endtask

    task automatic seek_to(logic [32:0] off, origin_t org);
        fat_cmd_t c;
        c = blank_cmd(OP_SEEK);
        c.seek_offset = off;
        c.seek_origin = org;
        send_cmd(c);
    endtask

    task automatic read_req(logic [31:0] len, logic [31:0] buf_size);
        fat_cmd_t c;
        c = blank_cmd(OP_READ);
        c.read_length = len;
        c.buffer_size = buf_size;
        send_cmd(c);
    endtask

    // Wait until every expected word is back and the engine has settled
    task automatic drain();
        stop_sending();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    // Register write then read back, APB setup and access phases
    task automatic reg_write(reg_index_t idx, logic [31:0] val);
        logic [31:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_BYTES_PER_SECTOR:    begin g_bps          = val[12:0]; want = g_bps;          end
            REG_SECTORS_PER_CLUSTER: begin g_spc          = val[7:0];  want = g_spc;          end
            REG_RESERVED_SECTORS:    begin g_reserved     = val[15:0]; want = g_reserved;     end
            REG_FAT_COUNT:           begin g_fat_count    = val[2:0];  want = g_fat_count;    end
            REG_FAT_SIZE:            begin g_fat_size     = val[15:0]; want = g_fat_size;     end
            default:                 begin g_root_entries = val[15:0]; want = g_root_entries; end
        endcase
        if (prdata !== want)
            report_mismatch("register readback", prdata, want);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(logic [31:0] bps, logic [31:0] spc, logic [31:0] res,
                                logic [31:0] fc, logic [31:0] fs, logic [31:0] rec);
        drain();
        reg_write(REG_BYTES_PER_SECTOR, bps);
        reg_write(REG_SECTORS_PER_CLUSTER, spc);
        reg_write(REG_RESERVED_SECTORS, res);
        reg_write(REG_FAT_COUNT, fc);
        reg_write(REG_FAT_SIZE, fs);
        reg_write(REG_ROOT_ENTRY_COUNT, rec);
    endtask

    // Receiver: random back-pressure, calm stretches, and long hold-offs
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 10);
    end

    // Result checker
    always @(posedge clk)
    begin
        seg_word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", m_tdata[63:0], 0);
            else
            begin
                w = expected_words.pop_front();
                if (m_tdata[2:0] !== w.status)
                    report_mismatch("status", m_tdata[2:0], w.status);
                if (m_tdata[38:3] !== w.disk_offset)
                    report_mismatch("disk_offset", m_tdata[38:3], w.disk_offset);
                if (m_tdata[58:39] !== w.byte_count)
                    report_mismatch("byte_count", m_tdata[58:39], w.byte_count);
                if (m_tdata[90:59] !== w.position)
                    report_mismatch("position", m_tdata[90:59], w.position);
                if (m_tlast !== w.last)
                    report_mismatch("last", m_tlast, w.last);
            end
            words_checked++;
        end
    end

    // Load the whole cluster pool: a single chain 2 -> 3 -> ... -> POOL_TOP -> end
    task automatic test_fat_load();
        for (int c = 2; c <= POOL_TOP; c++)
            fat_write(16'(c), (c == POOL_TOP) ? 16'hFFFF : 16'(c + 1));
    endtask

    task automatic test_directed();
        longint unsigned cs;
        cs = cluster_size();
        // table edges, never part of a chain
        fat_write(16'd0, 16'hFFFF);
        fat_write(16'hFFFF, 16'd0);
        // short chain 40 -> 41 -> 42 -> end
        fat_write(16'd40, 16'd41);
        fat_write(16'd41, 16'd42);
        fat_write(16'd42, 16'hFFF8);
        // rejected opens keep the old file
        open_file(16'd2, 32'd100, ATTR_DIR);
        open_file(16'd2, 32'd100, ATTR_VOLUME);
        open_file(16'd2, 32'd100, 8'hFF);
        // huge file: segment limit, empty reads
        open_file(16'd2, 32'hFFFF_FFFF, 8'hE7);
        read_req(32'd0, 32'hFFFF_FFFF);
        read_req(32'hFFFF_FFFF, 32'd0);
        read_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        seek_to(33'd0, ORG_BAD);
        seek_to(33'h1_FFFF_FFFF, ORG_START);
        seek_to(33'h1_0000_0001, ORG_CURRENT);
        seek_to(33'(cs + 7), ORG_START);
        seek_to(33'd5, ORG_CURRENT);
        // chain ends exactly at end of file
        open_file(16'd40, 32'(3 * cs), 8'h00);
        seek_to(33'd0, ORG_END);
        read_req(32'd10, 32'd10);
        seek_to(33'(cs + cs / 2), ORG_START);
        read_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // chain runs out before end of file
        open_file(16'd40, 32'(5 * cs), 8'h20);
        seek_to(33'(4 * cs), ORG_START);
        read_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        seek_to(33'd1, ORG_END);
        // unusable first cluster
        open_file(16'hFFFF, 32'd10, 8'h01);
        read_req(32'd4, 32'd4);
        open_file(16'd0, 32'd10, 8'h00);
        read_req(32'd4, 32'd4);
    endtask

    function automatic logic [15:0] pick_cluster();
        logic [15:0] ends [4] = '{16'd0, 16'd1, 16'hFFF8, 16'hFFFF};
        if ($urandom_range(0, 99) < 15)
            return ($urandom_range(0, 1) != 0) ? ends[$urandom_range(0, 3)]
                                               : 16'(16'hFFF8 + $urandom_range(0, 7));
        return 16'($urandom_range(2, POOL_TOP));
    endfunction

    // Random traffic sized to the current cluster; seeks stay within 16 clusters
    task automatic test_random(int count);
        longint unsigned cs;
        longint          target;
        longint          base;
        longint          lim;
        fat_cmd_t        c;
        int              pick;
        cs = cluster_size();
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            c = blank_cmd(OP_READ);
            if (pick < 15)
            begin
                c.op = OP_FAT_WRITE;
                if ($urandom_range(0, 3) != 0)
                    c.fat_index = 16'($urandom_range(2, POOL_TOP));
                c.fat_value = pick_cluster();
            end
            else if (pick < 30)
            begin
                c.op = OP_OPEN;
                c.first_cluster = pick_cluster();
                c.file_length   = 32'($urandom_range(0, 12) * cs + $urandom_range(0, cs - 1));
                if ($urandom_range(0, 99) < 80)
                    c.attributes = c.attributes & ~(ATTR_DIR | ATTR_VOLUME);
            end
            else if (pick < 60)
            begin
                c.op = OP_SEEK;
                if ($urandom_range(0, 99) < 80)
                begin
                    c.seek_origin = origin_t'($urandom_range(0, 2));
                    base   = (c.seek_origin == ORG_START) ? 0 :
                             (c.seek_origin == ORG_CURRENT) ? longint'(f_pos) : longint'(f_size);
                    lim    = (f_size < cs * 16) ? longint'(f_size) : longint'(cs * 16);
                    target = $urandom_range(0, 32'(lim));
                    c.seek_offset = 33'(target - base);
                end
                else if ($urandom_range(0, 1) != 0)
                    c.seek_origin = ORG_BAD;
                else
                begin
                    // negative target from the start
                    c.seek_origin = ORG_START;
                    c.seek_offset = {1'b1, $urandom()};
                end
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                c.read_length = $urandom_range(0, 32'(3 * cs));
                c.buffer_size = $urandom_range(0, 4) == 0 ? $urandom() : c.read_length + 5;
            end
            send_cmd(c);
        end
    endtask

    // Receiver holds off while reads keep coming, so the command queue backs up
    task automatic test_backpressure();
        longint unsigned cs;
        cs = cluster_size();
        drain();
        open_file(16'd2, 32'(20 * cs), 8'h00);
        hold_left = 1500;
        for (int i = 0; i < 6; i++)
            read_req(32'(2 * cs + 3), 32'hFFFF_FFFF);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_FAT_WRITE;
        m_tready      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        words_checked = 0;
        cmds_sent     = 0;
        cycle_count   = 0;
        hold_left     = 0;
        calm          = 1'b0;
        g_bps          = 13'd512;
        g_spc          = 8'd4;
        g_reserved     = 16'd1;
        g_fat_count    = 3'd2;
        g_fat_size     = 16'd256;
        g_root_entries = 16'd512;
        f_start   = '0;
        f_cluster = '0;
        f_size    = '0;
        f_pos     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry
        test_fat_load();
        test_directed();
        test_random(12);
        test_backpressure();
        // smallest legal geometry, no idling
        set_geometry(512, 1, 1, 1, 1, 0);
        calm = 1'b1;
        test_random(12);
        calm = 1'b0;
        // largest legal geometry
        set_geometry(4096, 128, 65535, 4, 65535, 65535);
        test_random(8);
        // all-ones fields: long segments split
        set_geometry(32'hFFFF_FFFF, 255, 65535, 7, 65535, 65535);
        test_directed();
        test_random(6);
        // zero geometry is taken as one-byte clusters
        set_geometry(0, 0, 3, 2, 9, 16);
        test_random(8);
        // mid-range
        set_geometry(1024, 8, 32, 2, 200, 224);
        test_random(6);
        drain();

        $display("sent %0d commands over six geometries, checked %0d result words",
                 cmds_sent, words_checked);
        $display("covered FAT loads, opens, seeks from every origin, clipped and split reads");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/fatre_pkg.sv
sv/fatre_front.sv
sv/fatre_div.sv
sv/fatre_back.sv
sv/fat16_file_read_address_engine.sv
dv/fat16_file_read_address_engine_tb.sv
